### design/mti_pkg.sv
// Shared types, widths, register codes and the triangle case table.
`default_nettype none
package mti_pkg;

  localparam int GRID_SIZE = 256;
  localparam int CELL_W    = 8;
  localparam int DENS_W    = 16;
  localparam int SPC_W     = 16;
  localparam int COORD_W   = 24;
  localparam int MAG_W     = DENS_W + 1;
  localparam int PROD_W    = MAG_W + SPC_W;
  localparam int REM_W     = PROD_W + 2;
  localparam int DIV_W     = MAG_W + 1;
  localparam int Q_W       = SPC_W + 1;
  localparam int LIM_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ISO     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING = 1'b1;
  localparam logic [SPC_W-1:0]     SPACING_RESET = 16'd25600;

  typedef logic [COORD_W-1:0]       coord_t;
  typedef logic signed [DENS_W-1:0] dens_t;

  typedef struct packed {
    dens_t            iso;
    logic [SPC_W-1:0] spacing;
  } cfg_t;

  typedef struct packed {
    coord_t base_x;
    coord_t base_y;
    logic   interp;
    logic   move_x;
    logic   neg_x;
    logic   move_y;
    logic   neg_y;
    dens_t  dp;
    dens_t  dq;
    logic   last;
  } job_t;

  function automatic logic [2:0] vert_count(input logic [2:0] flags);
    logic [2:0] n;
    case (flags)
      3'd0:    n = 3'd0;
      3'd3:    n = 3'd6;
      3'd5:    n = 3'd6;
      3'd6:    n = 3'd6;
      default: n = 3'd3;
    endcase
    return n;
  endfunction

  // Entry = first corner * 4 + second corner; equal corners mean the corner itself.
  function automatic logic [3:0] vert_entry(input logic [2:0] flags, input logic [2:0] slot);
    logic [3:0] e;
    case ({flags, slot})
      6'o11:   e = 4'd1;
      6'o12:   e = 4'd2;
      6'o20:   e = 4'd5;
      6'o21:   e = 4'd4;
      6'o22:   e = 4'd6;
      6'o31:   e = 4'd6;
      6'o32:   e = 4'd2;
      6'o34:   e = 4'd5;
      6'o35:   e = 4'd6;
      6'o40:   e = 4'd10;
      6'o41:   e = 4'd8;
      6'o42:   e = 4'd6;
      6'o51:   e = 4'd1;
      6'o52:   e = 4'd6;
      6'o53:   e = 4'd10;
      6'o55:   e = 4'd6;
      6'o60:   e = 4'd5;
      6'o61:   e = 4'd10;
      6'o62:   e = 4'd1;
      6'o63:   e = 4'd10;
      6'o64:   e = 4'd8;
      6'o65:   e = 4'd1;
      6'o71:   e = 4'd5;
      6'o72:   e = 4'd10;
      default: e = 4'd0;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

### design/mti_ifs.sv
// Channel interfaces: cell input, vertex output and register write.
`default_nettype none
interface mti_cell_if;
  import mti_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_x;
  logic [CELL_W-1:0] cell_y;
  dens_t             dens_a;
  dens_t             dens_b;
  dens_t             dens_c;
  dens_t             dens_d;
  modport source(output valid, cell_x, cell_y, dens_a, dens_b, dens_c, dens_d, input ready);
  modport sink(input valid, cell_x, cell_y, dens_a, dens_b, dens_c, dens_d, output ready);
endinterface

interface mti_vert_if;
  import mti_pkg::*;
  logic   valid;
  logic   ready;
  coord_t vert_x;
  coord_t vert_y;
  logic   last_vertex;
  modport source(output valid, vert_x, vert_y, last_vertex, input ready);
  modport sink(input valid, vert_x, vert_y, last_vertex, output ready);
endinterface

interface mti_cfg_if;
  import mti_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/mti_front.sv
// Front end: holds one cell, classifies both triangles; one vertex request per unstalled cycle.
`default_nettype none
module mti_front (
  input  logic          clk,
  input  logic          rst_n,
  mti_cell_if.sink      in_cell,
  input  mti_pkg::cfg_t cfg,
  output mti_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_ready
);
  import mti_pkg::*;

  localparam logic [LIM_W-1:0] LIMIT = LIM_W'(GRID_SIZE - 1);

  logic       cell_v_r;
  logic       oob_r;
  logic [3:0] idx_r;
  coord_t     x0_r, x1_r, y0_r, y1_r;
  dens_t      da_r, db_r, dc_r, dd_r;

  logic [2:0] flags0, flags1, cnt0, cnt1, slot;
  logic [3:0] total, ent;
  logic       in_tri1, done, accept;
  coord_t     x0_nxt, y0_nxt;

  always_comb begin
    coord_t     tx [0:3];
    coord_t     ty [0:3];
    dens_t      td [0:3];
    logic [1:0] pi, qi;
    logic       hit_p, hit_q;

    flags0 = {dc_r > cfg.iso, dd_r > cfg.iso, da_r > cfg.iso};
    flags1 = {dd_r > cfg.iso, db_r > cfg.iso, da_r > cfg.iso};
    cnt0   = vert_count(flags0);
    cnt1   = vert_count(flags1);
    total  = oob_r ? 4'd0 : ({1'b0, cnt0} + {1'b0, cnt1});
    in_tri1 = idx_r >= {1'b0, cnt0};
    slot   = in_tri1 ? 3'(idx_r - {1'b0, cnt0}) : idx_r[2:0];
    ent    = vert_entry(in_tri1 ? flags1 : flags0, slot);
    pi     = ent[3:2];
    qi     = ent[1:0];

    tx[0] = x0_r; ty[0] = y0_r; td[0] = da_r;
    if (in_tri1) begin
      tx[1] = x1_r; ty[1] = y0_r; td[1] = db_r;
      tx[2] = x1_r; ty[2] = y1_r; td[2] = dd_r;
    end else begin
      tx[1] = x1_r; ty[1] = y1_r; td[1] = dd_r;
      tx[2] = x0_r; ty[2] = y1_r; td[2] = dc_r;
    end
    tx[3] = x0_r; ty[3] = y0_r; td[3] = da_r;

    hit_p = (pi == qi) || (td[pi] == cfg.iso) || (td[pi] == td[qi]);
    hit_q = !hit_p && (td[qi] == cfg.iso);

    job.base_x = hit_q ? tx[qi] : tx[pi];
    job.base_y = hit_q ? ty[qi] : ty[pi];
    job.interp = !hit_p && !hit_q;
    job.move_x = tx[qi] != tx[pi];
    job.neg_x  = tx[qi] < tx[pi];
    job.move_y = ty[qi] != ty[pi];
    job.neg_y  = ty[qi] < ty[pi];
    job.dp     = td[pi];
    job.dq     = td[qi];
    job.last   = idx_r == (total - 4'd1);
  end

  assign job_valid     = cell_v_r && (total != 4'd0);
  assign done          = (total == 4'd0) || (job_ready && job.last);
  assign in_cell.ready = !cell_v_r || done;
  assign accept        = in_cell.valid && in_cell.ready;
  assign x0_nxt = COORD_W'({16'b0, in_cell.cell_x} * {8'b0, cfg.spacing});
  assign y0_nxt = COORD_W'({16'b0, in_cell.cell_y} * {8'b0, cfg.spacing});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_v_r <= 1'b0;
      idx_r    <= 4'd0;
    end else if (accept) begin
      cell_v_r <= 1'b1;
      idx_r    <= 4'd0;
    end else if (cell_v_r && done) begin
      cell_v_r <= 1'b0;
    end else if (job_valid && job_ready) begin
      idx_r <= idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      oob_r <= ({5'b0, in_cell.cell_x} >= LIMIT) || ({5'b0, in_cell.cell_y} >= LIMIT);
      x0_r  <= x0_nxt;
      x1_r  <= x0_nxt + {8'b0, cfg.spacing};
      y0_r  <= y0_nxt;
      y1_r  <= y0_nxt + {8'b0, cfg.spacing};
      da_r  <= in_cell.dens_a;
      db_r  <= in_cell.dens_b;
      dc_r  <= in_cell.dens_c;
      dd_r  <= in_cell.dens_d;
    end
  end

endmodule
`default_nettype wire

### design/mti_queue.sv
// Four-entry request queue between the front end and the vertex pipeline.
`default_nettype none
module mti_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  mti_pkg::job_t push_job,
  input  logic          push_valid,
  output logic          push_ready,
  output mti_pkg::job_t pop_job,
  output logic          pop_valid,
  input  logic          pop_ready
);
  import mti_pkg::*;

  job_t       mem [0:3];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;
  logic       push, pop;

  assign push_ready = count_r != 3'd4;
  assign pop_valid  = count_r != 3'd0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      if (push && !pop) count_r <= count_r + 3'd1;
      else if (pop && !push) count_r <= count_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

endmodule
`default_nettype wire

### design/mti_back.sv
// Vertex pipeline: multiply, pipelined rounding divider, coordinate step, output register.
`default_nettype none
module mti_back (
  input  logic          clk,
  input  logic          rst_n,
  input  mti_pkg::cfg_t cfg,
  input  mti_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_ready,
  mti_vert_if.source    out_vert
);
  import mti_pkg::*;

  logic             v_r   [0:Q_W];
  logic [REM_W-1:0] rem_r [0:Q_W];
  logic [DIV_W-1:0] d_r   [0:Q_W];
  logic [Q_W-1:0]   q_r   [0:Q_W];
  job_t             job_r [0:Q_W];

  logic [REM_W-1:0] rem_nxt [1:Q_W];
  logic [Q_W-1:0]   q_nxt   [1:Q_W];

  logic             out_v_r;
  coord_t           vx_r, vy_r;
  logic             last_r;
  logic             adv;
  logic [MAG_W-1:0] an_mag, ad_mag;
  logic signed [MAG_W-1:0] diff_n, diff_d;
  job_t             tail;
  coord_t           t;

  assign adv       = !out_v_r || out_vert.ready;
  assign job_ready = adv;

  assign diff_n = MAG_W'(cfg.iso) - MAG_W'(job.dp);
  assign diff_d = MAG_W'(job.dq) - MAG_W'(job.dp);
  assign an_mag = diff_n[MAG_W-1] ? MAG_W'(-diff_n) : diff_n;
  assign ad_mag = diff_d[MAG_W-1] ? MAG_W'(-diff_d) : diff_d;

  // One quotient bit per stage; numerator is 2*|num| + |den| for round-half-away.
  always_comb begin
    logic [REM_W-1:0] rin;
    logic [REM_W:0]   trial;
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0)
        rin = {rem_r[0][REM_W-2:0], 1'b0} + REM_W'(d_r[0][DIV_W-1:1]);
      else
        rin = rem_r[k];
      trial = {1'b0, rin} - ((REM_W+1)'(d_r[k]) << (Q_W - 1 - k));
      if (!trial[REM_W]) begin
        rem_nxt[k+1] = trial[REM_W-1:0];
        q_nxt[k+1]   = q_r[k] | (Q_W'(1) << (Q_W - 1 - k));
      end else begin
        rem_nxt[k+1] = rin;
        q_nxt[k+1]   = q_r[k];
      end
    end
  end

  assign tail = job_r[Q_W];
  assign t    = COORD_W'(q_r[Q_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= Q_W; k++) v_r[k] <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v_r[0] <= job_valid;
      for (int k = 1; k <= Q_W; k++) v_r[k] <= v_r[k-1];
      out_v_r <= v_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= REM_W'(an_mag) * REM_W'(cfg.spacing);
      d_r[0]   <= {ad_mag, 1'b0};
      q_r[0]   <= '0;
      job_r[0] <= job;
      for (int k = 1; k <= Q_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        d_r[k]   <= d_r[k-1];
        q_r[k]   <= q_nxt[k];
        job_r[k] <= job_r[k-1];
      end
      if (tail.interp && tail.move_x)
        vx_r <= tail.neg_x ? tail.base_x - t : tail.base_x + t;
      else
        vx_r <= tail.base_x;
      if (tail.interp && tail.move_y)
        vy_r <= tail.neg_y ? tail.base_y - t : tail.base_y + t;
      else
        vy_r <= tail.base_y;
      last_r <= tail.last;
    end
  end

  assign out_vert.valid       = out_v_r;
  assign out_vert.vert_x      = vx_r;
  assign out_vert.vert_y      = vy_r;
  assign out_vert.last_vertex = last_r;

endmodule
`default_nettype wire

### design/marching_triangles_isosurface_core.sv
// Top level: register file, front end, request queue and vertex pipeline.
//
//  Channel    Dir  Carries                                        Handshake
//  in_cell    in   cell_x, cell_y, dens_a..dens_d                 valid/ready
//  out_vert   out  vert_x, vert_y, last_vertex                    valid/ready
//  cfg_wr     in   index (0 iso_threshold, 1 grid_spacing), data  valid/ready
//
// A cell holds the front end until every vertex it yields, up to twelve, has been issued,
// and the single vertex output port limits the rate at which vertices leave.
// From the queue a vertex passes one multiply stage, 17 divider stages
// and the output register. Reset clears all valid state and loads the register defaults.
// A stalled output freezes the vertex pipeline; the queue then fills and holds the front end.
`default_nettype none
module marching_triangles_isosurface_core (
  input logic        clk,
  input logic        rst_n,
  mti_cell_if.sink   in_cell,
  mti_vert_if.source out_vert,
  mti_cfg_if.sink    cfg_wr
);
  import mti_pkg::*;

  dens_t            iso_r;
  logic [SPC_W-1:0] spacing_r;
  cfg_t             cfg;
  job_t             f_job, q_job;
  logic             f_valid, f_ready, q_valid, q_ready;

  assign cfg_wr.ready = 1'b1;
  assign cfg.iso      = iso_r;
  assign cfg.spacing  = spacing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_r     <= '0;
      spacing_r <= SPACING_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_ISO:     iso_r     <= cfg_wr.data;
        REG_SPACING: spacing_r <= cfg_wr.data;
        default:     ;
      endcase
    end
  end

  mti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cell   (in_cell),
    .cfg       (cfg),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (f_ready)
  );

  mti_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_job   (f_job),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_job    (q_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  mti_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job       (q_job),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .out_vert  (out_vert)
  );

endmodule
`default_nettype wire

### design/mti_checker.sv
// Port-level checks for the core and the bind that attaches them.
`default_nettype none
module mti_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] vert_x,
  input logic [23:0] vert_y,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("vertex dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(vert_x) && $stable(vert_y))
    else $error("vertex changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("vertex valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("register port not ready");

endmodule

bind marching_triangles_isosurface_core mti_checker u_mti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_vert.valid),
  .out_ready (out_vert.ready),
  .vert_x    (out_vert.vert_x),
  .vert_y    (out_vert.vert_y),
  .cfg_ready (cfg_wr.ready)
);
`default_nettype wire
